[sv/kdeq_pkg.sv]
package kdeq_pkg;

   localparam int KEYS_DEFAULT  = 6;
   localparam int SLOTS_DEFAULT = 12;

   localparam int PIN_W   = 6;
   localparam int COUNT_W = 4;
   localparam int CODE_W  = 3;
   localparam int QCNT_W  = 4;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_TICKS = 1'b0,
      CSR_PRESSED_LEVEL  = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic push;
      logic stable;
   } lane_status_type;

endpackage

[sv/kdeq_lane.sv]
module kdeq_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           scan,
   input  logic                           pin_level,
   input  logic                           pressed_level,
   input  logic [kdeq_pkg::COUNT_W-1:0]   debounce_ticks,
   output kdeq_pkg::lane_status_type      status
);

   logic                         last_ff;
   logic                         last_in;
   logic                         stable_ff;
   logic                         stable_in;
   logic [kdeq_pkg::COUNT_W-1:0] count_ff;
   logic [kdeq_pkg::COUNT_W-1:0] count_in;
   logic [kdeq_pkg::COUNT_W-1:0] count_inc;
   logic                         raw;
   logic                         push;

   always_comb begin
      raw       = (pin_level == pressed_level);
      count_inc = count_ff + kdeq_pkg::COUNT_W'(1);
      last_in   = last_ff;
      stable_in = stable_ff;
      count_in  = count_ff;
      push      = 1'b0;
      if (scan) begin
         if (raw != last_ff) begin
            last_in  = raw;
            count_in = '0;
         end else if (count_ff < debounce_ticks) begin
            count_in = count_inc;
            if (count_inc == debounce_ticks && raw != stable_ff) begin
               stable_in = raw;
               push      = raw;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         stable_ff <= 1'b0;
         count_ff  <= '1;
      end else begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

   assign status.push   = push;
   assign status.stable = stable_in;

endmodule

[sv/kdeq_ring.sv]
module kdeq_ring #(
   parameter int NumKeys   = kdeq_pkg::KEYS_DEFAULT,
   parameter int RingSlots = kdeq_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan,
   input  logic                          pop,
   input  logic [NumKeys-1:0]            push,
   output logic                          event_valid,
   output logic [kdeq_pkg::CODE_W-1:0]   event_key,
   output logic [kdeq_pkg::QCNT_W-1:0]   queue_count
);

   localparam int PtrW = $clog2(RingSlots);
   localparam int SumW = $clog2(RingSlots + NumKeys);

   logic [kdeq_pkg::CODE_W-1:0] ring_ff [RingSlots];
   logic [kdeq_pkg::CODE_W-1:0] ring_in [RingSlots];
   logic [PtrW-1:0]             wptr_ff;
   logic [PtrW-1:0]             wptr_in;
   logic [PtrW-1:0]             rptr_ff;
   logic [PtrW-1:0]             rptr_in;
   logic [PtrW-1:0]             count_ff;
   logic [PtrW-1:0]             count_in;
   logic [PtrW-1:0]             wptr_run;
   logic [PtrW-1:0]             rptr_inc;
   logic [SumW-1:0]             pushes;
   logic [SumW-1:0]             total;
   logic [PtrW:0]               rptr_diff;

   always_comb begin
      ring_in     = ring_ff;
      wptr_run    = wptr_ff;
      pushes      = '0;
      wptr_in     = wptr_ff;
      rptr_in     = rptr_ff;
      count_in    = count_ff;
      total       = '0;
      rptr_diff   = '0;
      event_valid = 1'b0;
      event_key   = '0;
      rptr_inc    = (rptr_ff == PtrW'(RingSlots - 1)) ? '0 : rptr_ff + PtrW'(1);
      if (scan) begin
         for (int i = 0; i < NumKeys; i++) begin
            if (push[i]) begin
               ring_in[wptr_run] = kdeq_pkg::CODE_W'(i + 1);
               wptr_run = (wptr_run == PtrW'(RingSlots - 1)) ? '0 : wptr_run + PtrW'(1);
               pushes = pushes + SumW'(1);
            end
         end
         total = SumW'(count_ff) + pushes;
         if (total > SumW'(RingSlots - 1)) begin
            count_in = PtrW'(RingSlots - 1);
         end else begin
            count_in = total[PtrW-1:0];
         end
         wptr_in = wptr_run;
         if (wptr_run >= count_in) begin
            rptr_diff = {1'b0, wptr_run} - {1'b0, count_in};
         end else begin
            rptr_diff = {1'b0, wptr_run} + (PtrW+1)'(RingSlots) - {1'b0, count_in};
         end
         rptr_in = rptr_diff[PtrW-1:0];
      end else if (pop && count_ff != '0) begin
         event_valid = 1'b1;
         event_key   = ring_ff[rptr_ff];
         rptr_in     = rptr_inc;
         count_in    = count_ff - PtrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   assign queue_count = kdeq_pkg::QCNT_W'(count_in);

endmodule

[sv/key_debounce_event_queue.sv]
// Key debouncer bank with a press-event queue.
// req channel: one transfer per item. req_tuser selects the operation (scan tick
// or pop); req_tdata carries the raw pin levels, one bit per key, used on a scan.
// rsp channel: exactly one transfer per accepted item, in order. rsp_tuser is
// set when a pop returned a queued event; rsp_tdata holds the popped key code,
// the stable pressed mask and the queue fill after the item.
// csr port: debounce tick count (index 0) and pressed pin level (index 1),
// written while the block is idle.
// Latency: the result is presented the cycle after the request transfer.
// Throughput: one item per cycle while rsp_tready is high; all key lanes and the queue push merge
// update in the same cycle as the request transfer.
// Stall: the result sits in the output register; a new request is accepted
// in the cycle that register is freed by rsp_tready, else req_tready drops.
// Reset: all keys released with saturated counters, queue empty,
// debounce ticks 2, pressed level 0. No clearing pass.
module key_debounce_event_queue #(
   parameter int NumKeys   = kdeq_pkg::KEYS_DEFAULT,
   parameter int RingSlots = kdeq_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kdeq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [5:0] pin_levels
   input  logic                               req_tuser,  // [0] operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] event_key, [8:3] stable_pressed, [12:9] queue_count
   output logic [kdeq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser,  // [0] event_valid
   input  logic                               csr_we,
   input  logic [kdeq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kdeq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [kdeq_pkg::COUNT_W-1:0]     ticks_ff;
   logic                             level_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [kdeq_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                             rsp_user_ff;
   logic                             req_fire;
   logic                             scan;
   logic                             pop;
   kdeq_pkg::lane_status_type        status [NumKeys];
   logic [NumKeys-1:0]               push;
   logic [kdeq_pkg::PIN_W-1:0]       stable_pressed;
   logic                             event_valid;
   logic [kdeq_pkg::CODE_W-1:0]      event_key;
   logic [kdeq_pkg::QCNT_W-1:0]      queue_count;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign scan       = req_fire && (req_tuser == kdeq_pkg::OP_SCAN);
   assign pop        = req_fire && (req_tuser == kdeq_pkg::OP_POP);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= kdeq_pkg::COUNT_W'(2);
         level_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            kdeq_pkg::CSR_DEBOUNCE_TICKS: ticks_ff <= csr_wdata[kdeq_pkg::COUNT_W-1:0];
            kdeq_pkg::CSR_PRESSED_LEVEL:  level_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NumKeys; i++) begin : g_lane
      logic pin;
      if (i < kdeq_pkg::PIN_W) begin : g_pin
         assign pin = req_tdata[i];
      end else begin : g_nopin
         assign pin = 1'b0;
      end
      kdeq_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .scan           (scan),
         .pin_level      (pin),
         .pressed_level  (level_ff),
         .debounce_ticks (ticks_ff),
         .status         (status[i])
      );
      assign push[i] = status[i].push;
   end

   for (genvar b = 0; b < kdeq_pkg::PIN_W; b++) begin : g_stable
      if (b < NumKeys) begin : g_key
         assign stable_pressed[b] = status[b].stable;
      end else begin : g_none
         assign stable_pressed[b] = 1'b0;
      end
   end

   kdeq_ring #(
      .NumKeys   (NumKeys),
      .RingSlots (RingSlots)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .scan        (scan),
      .pop         (pop),
      .push        (push),
      .event_valid (event_valid),
      .event_key   (event_key),
      .queue_count (queue_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_user_ff <= event_valid;
         rsp_data_ff <= {3'b000, queue_count, stable_pressed, event_key};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
